>>> hdl/cdid_pkg.sv
package cdid_pkg;

    localparam int START_W  = 20;
    localparam int LENGTH_W = 16;
    localparam int ID_W     = 32;
    localparam int QUOT_W   = 14;
    localparam int DSUM_W   = 6;
    localparam int SUM_W    = 8;
    localparam int TOTAL_W  = 24;
    localparam int COUNT_W  = 8;

    localparam int MAX_TRACKS_DEF = 99;

    localparam int FRAMES_PER_SEC = 75;
    localparam int SUM_MOD        = 255;

    // Reciprocal constants for exact division by multiplication and shift.
    localparam int SHIFT_75    = 26;
    localparam int RECIP_75    = ((2 ** SHIFT_75) + FRAMES_PER_SEC - 1) / FRAMES_PER_SEC;
    localparam int SHIFT_10    = 17;
    localparam int RECIP_10    = ((2 ** SHIFT_10) + 9) / 10;
    localparam int SHIFT_100   = 20;
    localparam int RECIP_100   = ((2 ** SHIFT_100) + 99) / 100;
    localparam int SHIFT_1000  = 24;
    localparam int RECIP_1000  = ((2 ** SHIFT_1000) + 999) / 1000;
    localparam int SHIFT_10000 = 27;
    localparam int RECIP_10000 = ((2 ** SHIFT_10000) + 9999) / 10000;

endpackage

>>> hdl/cd_disc_id_unit.sv
// A result item for the last track passes through the quotient and digit sum registers into the result register.
// Throughput: one item per cycle; the three register stages (quotient, digit sum,
// accumulate and result) advance together and hold while a waiting result is stalled.
// Reset: synchronous and active low; it empties the pipeline and clears the digit sum,
// length total and track count.
module cd_disc_id_unit
    import cdid_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [START_W-1:0]  i_start_frame,
    input  logic [LENGTH_W-1:0] i_track_length,
    input  logic                i_last_track,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ID_W-1:0]     o_disc_id
);

    localparam int QPROD_W = START_W + START_W;
    localparam int DPROD_W = 2 * QUOT_W;

    logic                 w_advance;

    logic [QPROD_W-1:0]   w_q_prod;
    logic                 r1_valid;
    logic [QUOT_W-1:0]    r1_quot;
    logic [LENGTH_W-1:0]  r1_length;
    logic                 r1_last;

    logic [DPROD_W-1:0]   w_p10;
    logic [DPROD_W-1:0]   w_p100;
    logic [DPROD_W-1:0]   w_p1000;
    logic [DPROD_W-1:0]   w_p10000;
    logic [QUOT_W:0]      w_div_sum;
    logic [QUOT_W+3:0]    w_nines;
    logic [QUOT_W+3:0]    w_dsum;
    logic                 r2_valid;
    logic [DSUM_W-1:0]    r2_dsum;
    logic [LENGTH_W-1:0]  r2_length;
    logic                 r2_last;

    logic [SUM_W-1:0]     r_sum_total;
    logic [TOTAL_W-1:0]   r_len_total;
    logic [COUNT_W-1:0]   r_count;
    logic [SUM_W:0]       w_sum_raw;
    logic [SUM_W-1:0]     n_sum_total;
    logic [TOTAL_W-1:0]   n_len_total;
    logic [COUNT_W-1:0]   n_count;
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_out_id;
    logic [ID_W-1:0]      n_out_id;

    assign w_advance = !(r_out_valid && i_stall);
    assign o_stall   = !w_advance;
    assign o_valid   = r_out_valid;
    assign o_disc_id = r_out_id;

    // Seconds from frames by a reciprocal multiply.
    assign w_q_prod = QPROD_W'(i_start_frame) * QPROD_W'(RECIP_75);

    // The decimal digit sum of q equals q minus nine times the sum of q / 10^k.
    assign w_p10    = DPROD_W'(r1_quot) * DPROD_W'(RECIP_10);
    assign w_p100   = DPROD_W'(r1_quot) * DPROD_W'(RECIP_100);
    assign w_p1000  = DPROD_W'(r1_quot) * DPROD_W'(RECIP_1000);
    assign w_p10000 = DPROD_W'(r1_quot) * DPROD_W'(RECIP_10000);

    always_comb begin
        w_div_sum = (QUOT_W+1)'(w_p10 >> SHIFT_10)
                  + (QUOT_W+1)'(w_p100 >> SHIFT_100)
                  + (QUOT_W+1)'(w_p1000 >> SHIFT_1000)
                  + (QUOT_W+1)'(w_p10000 >> SHIFT_10000);
        w_nines   = ((QUOT_W+4)'(w_div_sum) << 3) + (QUOT_W+4)'(w_div_sum);
        w_dsum    = (QUOT_W+4)'(r1_quot) - w_nines;
    end

    always_comb begin
        n_sum_total = r_sum_total;
        n_len_total = r_len_total;
        n_count     = r_count;
        w_sum_raw   = {1'b0, r_sum_total} + (SUM_W+1)'(r2_dsum);
        if (r_count < COUNT_W'(MAX_TRACKS)) begin
            if (w_sum_raw >= (SUM_W+1)'(SUM_MOD)) begin
                n_sum_total = SUM_W'(w_sum_raw - (SUM_W+1)'(SUM_MOD));
            end else begin
                n_sum_total = SUM_W'(w_sum_raw);
            end
            n_len_total = r_len_total + TOTAL_W'(r2_length);
            n_count     = r_count + COUNT_W'(1);
        end
        n_out_id = (ID_W'(n_sum_total) << 24) | (ID_W'(n_len_total) << 8)
                 | ID_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_total <= '0;
            r_len_total <= '0;
            r_count     <= '0;
        end else if (w_advance) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid && r2_last;
            if (r2_valid) begin
                if (r2_last) begin
                    r_sum_total <= '0;
                    r_len_total <= '0;
                    r_count     <= '0;
                end else begin
                    r_sum_total <= n_sum_total;
                    r_len_total <= n_len_total;
                    r_count     <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r1_quot   <= w_q_prod[SHIFT_75 +: QUOT_W];
            r1_length <= i_track_length;
            r1_last   <= i_last_track;
            r2_dsum   <= w_dsum[DSUM_W-1:0];
            r2_length <= r1_length;
            r2_last   <= r1_last;
            r_out_id  <= n_out_id;
        end
    end

endmodule
